// ----- hw/rtl/bmf_pkg.sv -----
// bmf_pkg: shared constants for the box mean filter
// default size limits, configuration register indexes and field widths
// no dependencies
`default_nettype none
package bmf_pkg;
	localparam int MAX_PAD_WIDTH_DEF  = 2048;
	localparam int MAX_RADIUS_DEF     = 15;
	localparam int MAX_PAD_HEIGHT_DEF = 4096;

	localparam int PIX_W    = 8;
	localparam int RADIUS_W = 4;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// wide enough for any padded size comparison
	localparam int CMP_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = 4'd1;
	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;
endpackage
`default_nettype wire

// ----- hw/rtl/box_mean_filter_core.sv -----
// Square box mean filter over an 8-bit padded pixel stream.
// Pixels arrive on in_valid/in_ready/pixel, one per beat, in raster order,
// each row image_width + 2*radius pixels, image_height + 2*radius rows.
// Once a full (2r+1) x (2r+1) window is seen, every input beat yields one
// output beat on out_valid/out_ready with the rounded mean and row/frame
// end marks. Warm-up pixels (first 2r rows, first 2r columns of a row)
// give no output.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 radius,
// 1 image_width, 2 image_height); a write to one of these restarts the frame. Write only
// while idle.
// Timing: a pixel is read-modify-written against the row store and the
// column sum ram (a registered read, then the update in ST_CALC); a pixel
// without output then returns to ST_IDLE. A pixel with output goes on to
// the bit-serial divider by the box area and to ST_HOLD, which loads the
// output register; no new pixel is taken until the core is back in ST_IDLE.
// The output register lets the next pixel enter while a result waits; if the
// receiver stalls, the next result holds in the divider until the slot frees.
// Reset: asynchronous, returns to the default configuration and frame start.
// Column sums read as zero in the first row of a frame, so no clearing pass.
`default_nettype none
module box_mean_filter_core #(
	parameter int MAX_PAD_WIDTH  = bmf_pkg::MAX_PAD_WIDTH_DEF,
	parameter int MAX_RADIUS     = bmf_pkg::MAX_RADIUS_DEF,
	parameter int MAX_PAD_HEIGHT = bmf_pkg::MAX_PAD_HEIGHT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bmf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [bmf_pkg::PIX_W-1:0]      pixel,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [bmf_pkg::PIX_W-1:0]      avg_pixel,
	output logic                                end_of_row,
	output logic                                end_of_frame
);
	import bmf_pkg::*;

	localparam int BOX_MAX = 2 * MAX_RADIUS + 1;
	localparam int XW   = $clog2(MAX_PAD_WIDTH);
	localparam int YW   = $clog2(MAX_PAD_HEIGHT);
	localparam int RW   = $clog2(MAX_RADIUS + 1);
	localparam int LW   = $clog2(BOX_MAX + 1);
	localparam int SW   = $clog2(BOX_MAX);
	localparam int AW   = $clog2(BOX_MAX * BOX_MAX + 1);
	localparam int CSW  = $clog2(255 * BOX_MAX + 1);
	localparam int WSW  = $clog2(255 * BOX_MAX * BOX_MAX + 1);
	localparam int STORE_DEPTH = MAX_PAD_WIDTH * BOX_MAX;
	localparam int SAW  = $clog2(STORE_DEPTH);
	localparam int DIV_STEPS = PIX_W;
	localparam int DCW  = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_DIV, ST_HOLD} state_t;

	// configuration
	logic [RADIUS_W-1:0] radius_q;
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic                restart;

	// effective geometry
	logic [RW-1:0]    r_eff;
	logic [LW-1:0]    len;
	logic [AW-1:0]    area;
	logic [CMP_W-1:0] two_r, w_min, h_min, pad_w, pad_h;

	always_comb begin
		if (radius_q == '0) begin
			r_eff = RW'(1);
		end else if (CMP_W'(radius_q) > CMP_W'(MAX_RADIUS)) begin
			r_eff = RW'(MAX_RADIUS);
		end else begin
			r_eff = RW'(radius_q);
		end
		len   = LW'({r_eff, 1'b1});
		area  = AW'(len * len);
		two_r = CMP_W'(r_eff) << 1;
		w_min = (width_q == '0) ? CMP_W'(1) : CMP_W'(width_q);
		h_min = (height_q == '0) ? CMP_W'(1) : CMP_W'(height_q);
		pad_w = (w_min + two_r > CMP_W'(MAX_PAD_WIDTH)) ? CMP_W'(MAX_PAD_WIDTH)
			: w_min + two_r;
		pad_h = (h_min + two_r > CMP_W'(MAX_PAD_HEIGHT)) ? CMP_W'(MAX_PAD_HEIGHT)
			: h_min + two_r;
	end

	assign restart = cfg_we && (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH
		|| cfg_index == REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// position and window state
	state_t            state_q;
	logic [XW-1:0]     x_q;
	logic [YW-1:0]     y_q;
	logic [SW-1:0]     slot_q;
	logic [SW-1:0]     tap_q;
	logic [WSW-1:0]    ws_q;
	logic [CSW-1:0]    delay_q [BOX_MAX];
	logic [PIX_W-1:0]  pix_s1;

	logic              accept;
	logic              wr_en;
	logic [SAW-1:0]    store_addr;
	logic [PIX_W-1:0]  old_pix;
	logic [CSW-1:0]    cs_rd, cs_new;
	logic [WSW-1:0]    ws_new;
	logic              y_full, x_full, emit, last_x, last_y;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign wr_en    = (state_q == ST_CALC);
	assign store_addr = SAW'(slot_q) * SAW'(MAX_PAD_WIDTH) + SAW'(x_q);

	bmf_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_row_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (store_addr),
		.wdata (pix_s1),
		.re    (accept),
		.raddr (store_addr),
		.rdata (old_pix)
	);

	bmf_ram #(.WIDTH(CSW), .DEPTH(MAX_PAD_WIDTH)) u_col_sums (
		.clk   (clk),
		.we    (wr_en),
		.waddr (x_q),
		.wdata (cs_new),
		.re    (accept),
		.raddr (x_q),
		.rdata (cs_rd)
	);

	always_comb begin
		y_full = CMP_W'(y_q) >= CMP_W'(len);
		x_full = CMP_W'(x_q) >= CMP_W'(len);
		emit   = (CMP_W'(y_q) + CMP_W'(1) >= CMP_W'(len))
			&& (CMP_W'(x_q) + CMP_W'(1) >= CMP_W'(len));
		last_x = (CMP_W'(x_q) + CMP_W'(1) == pad_w);
		last_y = (CMP_W'(y_q) + CMP_W'(1) == pad_h);
		// first row of a frame sees zero column sums
		cs_new = ((y_q == '0) ? '0 : cs_rd) - (y_full ? CSW'(old_pix) : '0)
			+ CSW'(pix_s1);
		ws_new = ((x_q == '0) ? '0 : ws_q) - (x_full ? WSW'(delay_q[tap_q]) : '0)
			+ WSW'(cs_new);
	end

	// divider and output
	logic [AW-1:0]    rem_q;
	logic [PIX_W-1:0] dvd_q;
	logic [PIX_W-1:0] quo_q;
	logic [DCW-1:0]   step_q;
	logic             eor_q, eof_q;
	logic [WSW-1:0]   dividend;
	logic [AW:0]      trial;

	assign dividend = ws_new + WSW'(area >> 1);
	assign trial    = {rem_q, dvd_q[PIX_W-1]};

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			pix_s1 <= pixel;
		end
		if (wr_en) begin
			delay_q[tap_q] <= cs_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			x_q       <= '0;
			y_q       <= '0;
			slot_q    <= '0;
			tap_q     <= '0;
			ws_q      <= '0;
			rem_q     <= '0;
			dvd_q     <= '0;
			quo_q     <= '0;
			step_q    <= '0;
			eor_q     <= 1'b0;
			eof_q     <= 1'b0;
			out_valid <= 1'b0;
			avg_pixel <= '0;
			end_of_row   <= 1'b0;
			end_of_frame <= 1'b0;
		end else begin
			// the hold state reloads the output register itself
			if (out_valid && out_ready && state_q != ST_HOLD) begin
				out_valid <= 1'b0;
			end
			if (restart) begin
				x_q    <= '0;
				y_q    <= '0;
				slot_q <= '0;
				tap_q  <= '0;
				ws_q   <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					ws_q <= ws_new;
					if (last_x) begin
						x_q   <= '0;
						tap_q <= '0;
						if (last_y) begin
							y_q    <= '0;
							slot_q <= '0;
						end else begin
							y_q    <= y_q + YW'(1);
							slot_q <= (CMP_W'(slot_q) + CMP_W'(1) == CMP_W'(len)) ? '0
								: slot_q + SW'(1);
						end
					end else begin
						x_q   <= x_q + XW'(1);
						tap_q <= (CMP_W'(tap_q) + CMP_W'(1) == CMP_W'(len)) ? '0
							: tap_q + SW'(1);
					end
					if (emit) begin
						rem_q   <= AW'(dividend >> PIX_W);
						dvd_q   <= dividend[PIX_W-1:0];
						step_q  <= '0;
						eor_q   <= last_x;
						eof_q   <= last_x && last_y;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					// one quotient bit per cycle, restoring
					if (trial >= {1'b0, area}) begin
						rem_q <= AW'(trial - {1'b0, area});
						quo_q <= {quo_q[PIX_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[AW-1:0];
						quo_q <= {quo_q[PIX_W-2:0], 1'b0};
					end
					dvd_q  <= dvd_q << 1;
					step_q <= step_q + DCW'(1);
					if (step_q == DCW'(DIV_STEPS - 1)) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (!out_valid || out_ready) begin
						out_valid    <= 1'b1;
						avg_pixel    <= quo_q;
						end_of_row   <= eor_q;
						end_of_frame <= eof_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/bmf_ram.sv -----
// bmf_ram: generic single-write, single-read synchronous ram
// read data registered; no dependencies
`default_nettype none
module bmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire
